@@ hw/rtl/clmv_pkg.sv @@
// ----------------------------------------------------------------------------
// clmv_pkg: shared types and constants of the cluster label majority vote
// Label and count widths, the sequencer states and the slot cell controls.
// ----------------------------------------------------------------------------
package clmv_pkg;

  localparam int unsigned LabelW  = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned FracW   = 9;
  localparam int unsigned ClustW  = 6;
  // Number of label fields that an input request carries.
  localparam int unsigned LabelFields = 3;
  localparam int unsigned LIdxW   = 2;

  localparam logic [LabelW-1:0] LabelNone = '1;
  localparam logic [CountW-1:0] CountMax  = '1;
  localparam logic [FracW-1:0]  FracReset = 9'd128;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LABEL,
    ST_SCAN,
    ST_EMIT
  } clmv_state_e;

  // Controls broadcast to every slot cell.
  typedef struct packed {
    logic              tally;
    logic              shift;
    logic              hit;
    logic [LabelW-1:0] label;
  } clmv_ctrl_t;

endpackage

@@ hw/rtl/clmv_cell.sv @@
// ----------------------------------------------------------------------------
// clmv_cell: one label slot of the vote table
// Holds a label and its count, matches a broadcast label, takes a new label
// when it is the first free slot, and shifts toward slot zero during the scan.
// ----------------------------------------------------------------------------
module clmv_cell #(
  parameter bit IS_LAST = 1'b0
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  clmv_pkg::clmv_ctrl_t           ctrl_i,
  input  logic                           prev_used_i,
  input  logic [clmv_pkg::LabelW-1:0]    next_label_i,
  input  logic [clmv_pkg::CountW-1:0]    next_count_i,
  output logic [clmv_pkg::LabelW-1:0]    label_o,
  output logic [clmv_pkg::CountW-1:0]    count_o,
  output logic                           used_o,
  output logic                           match_o
);
  import clmv_pkg::*;

  logic [LabelW-1:0] label_q, label_d;
  logic [CountW-1:0] count_q, count_d;
  logic              target;
  logic [CountW-1:0] bumped;

  // A slot in use always has a nonzero count.
  assign used_o  = (count_q != '0);
  // The final slot is only ever overwritten, never matched.
  assign match_o = !IS_LAST && used_o && (label_q == ctrl_i.label);
  assign target  = IS_LAST ? prev_used_i : (!used_o && prev_used_i);
  assign bumped  = (count_q == CountMax) ? count_q : count_q + CountW'(1);

  always_comb begin
    label_d = label_q;
    count_d = count_q;
    if (ctrl_i.shift) begin
      label_d = next_label_i;
      count_d = next_count_i;
    end else if (ctrl_i.tally) begin
      if (match_o) begin
        count_d = bumped;
      end else if (!ctrl_i.hit && target) begin
        label_d = ctrl_i.label;
        count_d = bumped;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      label_q <= LabelNone;
      count_q <= '0;
    end else begin
      label_q <= label_d;
      count_q <= count_d;
    end
  end

  assign label_o = label_q;
  assign count_o = count_q;

endmodule

@@ hw/rtl/cluster_label_majority_vote.sv @@
// Flow: a final cluster steps through its label fields in ST_LABEL, then ST_SCAN
// shifts every slot past slot zero and ST_EMIT loads the output register, waiting
// while the output is stalled; a last cluster past MAX_CLUSTERS skips ST_LABEL.
// A new cluster is accepted only in ST_IDLE, once the previous one is tallied; a
// full table ends a cluster early, and one past MAX_CLUSTERS without last is not tallied.
// Reset clears the slot table, the counters and the output valid at once.
// ----------------------------------------------------------------------------
// cluster_label_majority_vote: track label vote over the clusters of a run
// Tallies cluster labels in a chain of slot cells and, on the last cluster,
// reports the first slot whose count reaches the fractional threshold.
// ----------------------------------------------------------------------------
module cluster_label_majority_vote #(
  parameter int unsigned MAX_CLUSTERS       = 32,
  parameter int unsigned SLOTS              = 10,
  parameter int unsigned LABELS_PER_CLUSTER = 3
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [clmv_pkg::FracW-1:0]     cfg_wdata_i,   // frac_q8
  input  logic                           s_tvalid_i,
  output logic                           s_tready_o,
  input  logic [3*clmv_pkg::LabelW-1:0]  s_tdata_i,     // label_a, label_b, label_c
  input  logic                           s_tlast_i,
  output logic                           m_tvalid_o,
  input  logic                           m_tready_i,
  output logic [clmv_pkg::LabelW-1:0]    m_tdata_o,     // track_label
  output logic                           m_tuser_o      // found
);
  import clmv_pkg::*;

  localparam int unsigned ScanW = $clog2(SLOTS);

  clmv_state_e       state_q, state_d;
  logic [FracW-1:0]  frac_q;
  logic [ClustW-1:0] clust_q, clust_d;
  logic [LabelW-1:0] lab_q [LabelFields];
  logic              last_q, last_d;
  logic [LIdxW-1:0]  idx_q, idx_d;
  logic [ScanW-1:0]  scan_q, scan_d;
  logic              res_hit_q, res_hit_d;
  logic [LabelW-1:0] res_label_q, res_label_d;
  logic              out_valid_q, out_valid_d;
  logic [LabelW-1:0] out_label_q, out_label_d;
  logic              out_found_q, out_found_d;

  clmv_ctrl_t        ctrl;
  logic [LabelW-1:0] cell_label [SLOTS];
  logic [CountW-1:0] cell_count [SLOTS];
  logic [SLOTS-1:0]  used_w;
  logic [SLOTS-1:0]  match_w;
  logic              accept;
  logic              counted;
  logic              full_alloc;
  logic              label_end;
  logic [FracW+ClustW-1:0] prod;
  logic [CountW-1:0] thr;
  logic [LabelW-1:0] cur_label;

  assign accept     = s_tvalid_i && s_tready_o;
  assign counted    = (clust_q < ClustW'(MAX_CLUSTERS));
  assign cur_label  = lab_q[idx_q];
  assign prod       = {{ClustW{1'b0}}, frac_q} * {{FracW{1'b0}}, clust_q};
  assign thr        = prod[8 +: CountW];
  // A label that misses every searched slot while the one before the final
  // slot is taken lands in the final slot and ends the cluster.
  assign full_alloc = !ctrl.hit && used_w[SLOTS-2];
  assign label_end  = (idx_q == LIdxW'(LABELS_PER_CLUSTER - 1)) ||
                      (ctrl.tally && full_alloc);

  always_comb begin
    ctrl.label = cur_label;
    ctrl.hit   = |match_w;
    ctrl.tally = (state_q == ST_LABEL) && (cur_label != LabelNone);
    ctrl.shift = (state_q == ST_SCAN);
  end

  for (genvar j = 0; j < SLOTS; j++) begin : g_cell
    logic              prev_used;
    logic [LabelW-1:0] nxt_label;
    logic [CountW-1:0] nxt_count;
    if (j == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_rest
      assign prev_used = used_w[j-1];
    end
    if (j == SLOTS - 1) begin : g_tail
      assign nxt_label = LabelNone;
      assign nxt_count = '0;
    end else begin : g_body
      assign nxt_label = cell_label[j+1];
      assign nxt_count = cell_count[j+1];
    end
    clmv_cell #(
      .IS_LAST (j == SLOTS - 1)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prev_used_i  (prev_used),
      .next_label_i (nxt_label),
      .next_count_i (nxt_count),
      .label_o      (cell_label[j]),
      .count_o      (cell_count[j]),
      .used_o       (used_w[j]),
      .match_o      (match_w[j])
    );
  end

  assign s_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    clust_d     = clust_q;
    last_d      = last_q;
    idx_d       = idx_q;
    scan_d      = scan_q;
    res_hit_d   = res_hit_q;
    res_label_d = res_label_q;
    out_valid_d = out_valid_q && !m_tready_i;
    out_label_d = out_label_q;
    out_found_d = out_found_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d      = s_tlast_i;
          idx_d       = '0;
          scan_d      = '0;
          res_hit_d   = 1'b0;
          res_label_d = LabelNone;
          if (counted) begin
            clust_d = clust_q + ClustW'(1);
            state_d = ST_LABEL;
          end else if (s_tlast_i) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_LABEL: begin
        idx_d = idx_q + LIdxW'(1);
        if (label_end) begin
          state_d = last_q ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Slot zero sees the table in slot order as the chain shifts down.
        if (!res_hit_q && (cell_count[0] >= thr)) begin
          res_hit_d   = 1'b1;
          res_label_d = cell_label[0];
        end
        scan_d = scan_q + ScanW'(1);
        if (scan_q == ScanW'(SLOTS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_tready_i) begin
          out_valid_d = 1'b1;
          out_label_d = res_label_q;
          out_found_d = (res_label_q != LabelNone);
          clust_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frac_q      <= FracReset;
      clust_q     <= '0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      scan_q      <= '0;
      res_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clust_q     <= clust_d;
      last_q      <= last_d;
      idx_q       <= idx_d;
      scan_q      <= scan_d;
      res_hit_q   <= res_hit_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        frac_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_label_q <= res_label_d;
    out_label_q <= out_label_d;
    out_found_q <= out_found_d;
    if (accept) begin
      for (int i = 0; i < LabelFields; i++) begin
        lab_q[i] <= s_tdata_i[i*LabelW +: LabelW];
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_label_q;
  assign m_tuser_o  = out_found_q;

`ifndef SYNTHESIS
  logic [SLOTS-2:0] used_searched;
  assign used_searched = used_w[SLOTS-2:0];

  // Searched slots fill from slot zero upward without gaps.
  a_used_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (used_searched & (used_searched + 1'b1)) == '0)
    else $error("slot table has a gap");

  // Searched slots hold distinct labels, so a label hits at most one.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.tally |-> $onehot0(match_w))
    else $error("label matches more than one slot");

  // The scan shifts the whole table out, leaving it empty.
  a_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (used_w == '0))
    else $error("slot table not empty after scan");

  a_clust_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clust_q <= ClustW'(MAX_CLUSTERS))
    else $error("cluster count past its limit");
`endif

endmodule
